@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the raw-to-XYZ block.
// No dependencies; clock and reset are named i_clk and i_rst_n at the use site.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTXC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RTXC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RTXC_ASSERT(lbl, prop, msg)
`define RTXC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ sv/rtxc_pkg.sv @@
// Shared constants and types for the raw-to-XYZ and chromaticity pipeline.
// No dependencies.
package rtxc_pkg;
    localparam int NSTAGE      = 16;   // register stages, input to output
    localparam int FRAC_BITS   = 16;
    localparam int SCALE_SHIFT = 24;
    localparam int TRI_W       = 32;
    localparam int CHR_W       = 18;
    localparam int SUM_W       = TRI_W + 2;
    localparam int DIVS_W      = TRI_W + 1;          // positive sum magnitude
    localparam int MAG_W       = TRI_W + FRAC_BITS;  // |t| << 16
    localparam int DIVD_W      = MAG_W + 1;          // plus half the divisor
    localparam int QBITS       = CHR_W;
    localparam int DIV_PER     = 2;                  // quotient bits per stage
    localparam int DIV_STAGES  = QBITS / DIV_PER;
    localparam int CHROMA_MAX  = 131071;
    localparam int CHROMA_LIM  = 131072;
    localparam int CHROMA_EN_W = DIV_STAGES + 3;    // sum, div prep, steps, output

    typedef enum logic [1:0] {
        REG_ROW_X = 2'd0,
        REG_ROW_Y = 2'd1,
        REG_ROW_Z = 2'd2,
        REG_EXPO  = 2'd3
    } t_reg_idx;

    typedef logic [TRI_W-1:0] t_tri;
endpackage

@@ sv/rtxc_scale.sv @@
// Exposure scaling: raw Q16.8 times Q0.32 scale, rounded to Q16.16, reordered to X, Y, Z.
// Depends on rtxc_pkg. Two register stages.
module rtxc_scale #(
    parameter int RAW_WIDTH = 24
) (
    input  logic                        i_clk,
    input  logic [1:0]                  i_en,
    input  logic [RAW_WIDTH-1:0]        i_raw_z,
    input  logic [RAW_WIDTH-1:0]        i_raw_x,
    input  logic [RAW_WIDTH-1:0]        i_raw_y,
    input  logic [31:0]                 i_scale,
    output logic [2:0][RAW_WIDTH+7:0]   o_v
);
    import rtxc_pkg::*;

    localparam int PW = RAW_WIDTH + 32;

    logic [2:0][RAW_WIDTH-1:0] raw;
    logic [PW-1:0]             r_p [3];
    logic [2:0][RAW_WIDTH+7:0] r_v;
    logic [PW-1:0]             rnd [3];

    assign raw[0] = i_raw_x;
    assign raw[1] = i_raw_y;
    assign raw[2] = i_raw_z;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_en[0]) begin
                r_p[k] <= PW'(raw[k]) * PW'(i_scale);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rnd[k] = r_p[k] + (PW'(1) << (SCALE_SHIFT - 1));
        end
    end

    // sum cannot carry out of PW bits, so the rounded value fits RAW_WIDTH+8
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_en[1]) begin
                r_v[k] <= rnd[k][PW-1:SCALE_SHIFT];
            end
        end
    end

    assign o_v = r_v;
endmodule

@@ sv/rtxc_matrix.sv @@
// 3x3 calibration matrix: nine registered products, then row sums rounded and saturated.
// Depends on rtxc_pkg. Two register stages.
module rtxc_matrix #(
    parameter int RAW_WIDTH   = 24,
    parameter int COEFF_WIDTH = 20
) (
    input  logic                          i_clk,
    input  logic [1:0]                    i_en,
    input  logic [2:0][RAW_WIDTH+7:0]     i_v,
    input  logic [2:0][3*COEFF_WIDTH-1:0] i_row,
    output rtxc_pkg::t_tri [2:0]          o_tri
);
    import rtxc_pkg::*;

    localparam int PW = COEFF_WIDTH + RAW_WIDTH + 9;
    localparam int AW = PW + 2;

    logic signed [PW-1:0] prod  [3][3];
    logic signed [PW-1:0] r_prod [3][3];
    logic signed [AW-1:0] acc [3];
    logic signed [AW-1:0] sh  [3];
    t_tri [2:0]           tri_n;
    t_tri [2:0]           r_tri;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                prod[r][k] = PW'($signed(i_row[r][k*COEFF_WIDTH +: COEFF_WIDTH]))
                           * PW'($signed({1'b0, i_v[k]}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= prod;
        end
    end

    // round half up, floor shift, then clamp to 32-bit signed
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = AW'(r_prod[r][0]) + AW'(r_prod[r][1]) + AW'(r_prod[r][2])
                   + (AW'(1) << (FRAC_BITS - 1));
            sh[r]  = acc[r] >>> FRAC_BITS;
            if (sh[r][AW-1:TRI_W-1] == '0 || sh[r][AW-1:TRI_W-1] == '1) begin
                tri_n[r] = sh[r][TRI_W-1:0];
            end else if (sh[r][AW-1]) begin
                tri_n[r] = {1'b1, {(TRI_W-1){1'b0}}};
            end else begin
                tri_n[r] = {1'b0, {(TRI_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_tri <= tri_n;
        end
    end

    assign o_tri = r_tri;
endmodule

@@ sv/rtxc_div.sv @@
// Pipelined restoring divider for chromaticity: (mag + sum/2) / sum, 18 quotient bits.
// Depends on rtxc_pkg. One prep stage plus DIV_STAGES steps of DIV_PER bits.
module rtxc_div (
    input  logic                          i_clk,
    input  logic [rtxc_pkg::DIV_STAGES:0] i_en,
    input  logic [rtxc_pkg::MAG_W-1:0]    i_mag,
    input  logic [rtxc_pkg::DIVS_W-1:0]   i_sum,
    output logic [rtxc_pkg::QBITS-1:0]    o_q,
    output logic                          o_ovf
);
    import rtxc_pkg::*;

    localparam int CW = DIVS_W + QBITS;   // compare width

    logic [DIVD_W-1:0] r_rem [DIV_STAGES+1];
    logic [DIVS_W-1:0] r_s   [DIV_STAGES+1];
    logic [QBITS-1:0]  r_q   [DIV_STAGES+1];
    logic              r_ovf [DIV_STAGES+1];
    logic [DIVD_W-1:0] dvd;

    assign dvd = DIVD_W'(i_mag) + DIVD_W'(i_sum >> 1);

    // quotient of 2^18 or more saturates anyway, so flag it up front
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= dvd;
            r_s[0]   <= i_sum;
            r_q[0]   <= '0;
            r_ovf[0] <= CW'(dvd) >= (CW'(i_sum) << QBITS);
        end
    end

    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_step
        logic [DIVD_W-1:0] rem_t;
        logic [QBITS-1:0]  q_t;

        always_comb begin
            logic [CW-1:0] trial;
            rem_t = r_rem[j-1];
            q_t   = r_q[j-1];
            for (int b = 0; b < DIV_PER; b++) begin
                trial = CW'(r_s[j-1]) << (QBITS - 1 - (j - 1) * DIV_PER - b);
                if (CW'(rem_t) >= trial) begin
                    rem_t = rem_t - trial[DIVD_W-1:0];
                    q_t[QBITS - 1 - (j - 1) * DIV_PER - b] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= rem_t;
                r_q[j]   <= q_t;
                r_s[j]   <= r_s[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign o_q   = r_q[DIV_STAGES];
    assign o_ovf = r_ovf[DIV_STAGES];
endmodule

@@ sv/rtxc_chroma.sv @@
// Chromaticity: sum of X, Y, Z, two pipelined dividers, sign and saturation, output register.
// Depends on rtxc_pkg and rtxc_div.
module rtxc_chroma (
    input  logic                           i_clk,
    input  logic [rtxc_pkg::CHROMA_EN_W-1:0] i_en,
    input  rtxc_pkg::t_tri [2:0]           i_tri,
    output rtxc_pkg::t_tri [2:0]           o_tri,
    output logic [rtxc_pkg::CHR_W-1:0]     o_cx,
    output logic [rtxc_pkg::CHR_W-1:0]     o_cy,
    output logic                           o_inv
);
    import rtxc_pkg::*;

    localparam int LAST = DIV_STAGES + 1;

    logic signed [SUM_W-1:0] sum;
    logic [TRI_W-1:0]        magx, magy;
    logic [MAG_W-1:0]        r_magx, r_magy;
    logic [DIVS_W-1:0]       r_sum;

    t_tri [2:0] d_tri  [LAST+1];
    logic       d_inv  [LAST+1];
    logic       d_negx [LAST+1];
    logic       d_negy [LAST+1];

    logic [QBITS-1:0] qx, qy;
    logic             ovfx, ovfy;

    t_tri [2:0]        r_tri;
    logic [CHR_W-1:0]  r_cx, r_cy;
    logic              r_inv;

    function automatic logic [CHR_W-1:0] fmt(input logic [QBITS-1:0] q, input logic ovf,
                                             input logic neg);
        logic [QBITS:0] qs;
        logic [QBITS:0] res;
        if (ovf || q > QBITS'(CHROMA_LIM)) begin
            qs = (QBITS+1)'(CHROMA_LIM);
        end else begin
            qs = {1'b0, q};
        end
        if (neg) begin
            res = -qs;
        end else if (qs > (QBITS+1)'(CHROMA_MAX)) begin
            res = (QBITS+1)'(CHROMA_MAX);
        end else begin
            res = qs;
        end
        return res[CHR_W-1:0];
    endfunction

    assign sum  = SUM_W'($signed(i_tri[0])) + SUM_W'($signed(i_tri[1]))
                + SUM_W'($signed(i_tri[2]));
    assign magx = i_tri[0][TRI_W-1] ? -i_tri[0] : i_tri[0];
    assign magy = i_tri[1][TRI_W-1] ? -i_tri[1] : i_tri[1];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sum     <= sum[DIVS_W-1:0];
            r_magx    <= {magx, {FRAC_BITS{1'b0}}};
            r_magy    <= {magy, {FRAC_BITS{1'b0}}};
            d_tri[0]  <= i_tri;
            d_inv[0]  <= sum[SUM_W-1] || (sum == '0);
            d_negx[0] <= i_tri[0][TRI_W-1];
            d_negy[0] <= i_tri[1][TRI_W-1];
        end
    end

    // side data rides along with the divider stages
    always_ff @(posedge i_clk) begin
        for (int m = 1; m <= LAST; m++) begin
            if (i_en[m]) begin
                d_tri[m]  <= d_tri[m-1];
                d_inv[m]  <= d_inv[m-1];
                d_negx[m] <= d_negx[m-1];
                d_negy[m] <= d_negy[m-1];
            end
        end
    end

    rtxc_div u_div_x (
        .i_clk (i_clk),
        .i_en  (i_en[LAST:1]),
        .i_mag (r_magx),
        .i_sum (r_sum),
        .o_q   (qx),
        .o_ovf (ovfx)
    );

    rtxc_div u_div_y (
        .i_clk (i_clk),
        .i_en  (i_en[LAST:1]),
        .i_mag (r_magy),
        .i_sum (r_sum),
        .o_q   (qy),
        .o_ovf (ovfy)
    );

    always_ff @(posedge i_clk) begin
        if (i_en[LAST+1]) begin
            r_tri <= d_tri[LAST];
            r_inv <= d_inv[LAST];
            r_cx  <= d_inv[LAST] ? '0 : fmt(qx, ovfx, d_negx[LAST]);
            r_cy  <= d_inv[LAST] ? '0 : fmt(qy, ovfy, d_negy[LAST]);
        end
    end

    assign o_tri = r_tri;
    assign o_cx  = r_cx;
    assign o_cy  = r_cy;
    assign o_inv = r_inv;
endmodule

@@ sv/raw_to_xyz_and_chromaticity_top.sv @@
// Raw sensor sample to calibrated XYZ and xy chromaticity; 16-stage pipeline.
// One transfer per cycle sustained while i_stall is low.
// Stage count is set by the 18-bit chromaticity divide, 2 quotient bits per stage.
// Each stage holds its item until the next frees up, so bubbles close under output stall.
// Synchronous active-low reset clears valid bits and loads the register reset values.
// Depends on rtxc_pkg, rtxc_scale, rtxc_matrix, rtxc_chroma, assert_macros.svh.
`include "assert_macros.svh"
module raw_to_xyz_and_chromaticity_top #(
    parameter int RAW_WIDTH   = 24,
    parameter int COEFF_WIDTH = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [RAW_WIDTH-1:0]       i_raw_ch_z,
    input  logic [RAW_WIDTH-1:0]       i_raw_ch_x,
    input  logic [RAW_WIDTH-1:0]       i_raw_ch_y,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [31:0]         o_tristim_x,
    output logic signed [31:0]         o_tristim_y,
    output logic signed [31:0]         o_tristim_z,
    output logic signed [17:0]         o_chroma_x,
    output logic signed [17:0]         o_chroma_y,
    output logic                       o_chroma_invalid,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [4:0]                 paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);
    import rtxc_pkg::*;

    localparam int ROW_W = 3 * COEFF_WIDTH;

    logic [2:0][ROW_W-1:0]     r_row;
    logic [31:0]               r_expo;
    logic                      wr;
    t_reg_idx                  widx;

    logic [NSTAGE-1:0]         r_vld;
    logic [NSTAGE-1:0]         en;

    logic [2:0][RAW_WIDTH+7:0] v;
    t_tri [2:0]                tri_m;
    t_tri [2:0]                tri_o;
    logic [CHR_W-1:0]          cx, cy;
    logic                      inv;
    logic signed [SUM_W-1:0]   out_sum;

    // configuration port
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_row[k] <= ROW_W'(64'd65536 << (k * COEFF_WIDTH));
            end
            r_expo <= 32'd1048576000;
        end else if (wr) begin
            unique case (widx)
                REG_ROW_X: r_row[0] <= pwdata[ROW_W-1:0];
                REG_ROW_Y: r_row[1] <= pwdata[ROW_W-1:0];
                REG_ROW_Z: r_row[2] <= pwdata[ROW_W-1:0];
                REG_EXPO:  r_expo   <= pwdata[31:0];
                default:   r_expo   <= r_expo;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_ROW_X: prdata = 64'(r_row[0]);
            REG_ROW_Y: prdata = 64'(r_row[1]);
            REG_ROW_Z: prdata = 64'(r_row[2]);
            REG_EXPO:  prdata = 64'(r_expo);
            default:   prdata = '0;
        endcase
    end

    // a stage loads when it is empty or its successor loads
    always_comb begin
        en[NSTAGE-1] = !r_vld[NSTAGE-1] || !i_stall;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NSTAGE-1];

    rtxc_scale #(.RAW_WIDTH(RAW_WIDTH)) u_scale (
        .i_clk   (i_clk),
        .i_en    (en[1:0]),
        .i_raw_z (i_raw_ch_z),
        .i_raw_x (i_raw_ch_x),
        .i_raw_y (i_raw_ch_y),
        .i_scale (r_expo),
        .o_v     (v)
    );

    rtxc_matrix #(.RAW_WIDTH(RAW_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_matrix (
        .i_clk (i_clk),
        .i_en  (en[3:2]),
        .i_v   (v),
        .i_row (r_row),
        .o_tri (tri_m)
    );

    rtxc_chroma u_chroma (
        .i_clk (i_clk),
        .i_en  (en[NSTAGE-1:4]),
        .i_tri (tri_m),
        .o_tri (tri_o),
        .o_cx  (cx),
        .o_cy  (cy),
        .o_inv (inv)
    );

    assign o_tristim_x      = $signed(tri_o[0]);
    assign o_tristim_y      = $signed(tri_o[1]);
    assign o_tristim_z      = $signed(tri_o[2]);
    assign o_chroma_x       = $signed(cx);
    assign o_chroma_y       = $signed(cy);
    assign o_chroma_invalid = inv;

    assign out_sum = SUM_W'(o_tristim_x) + SUM_W'(o_tristim_y) + SUM_W'(o_tristim_z);

    `RTXC_ASSERT_RST(a_rst_clears, !i_rst_n |=> !o_valid, "output valid after reset")
    `RTXC_ASSERT(a_inv_zero, o_valid && o_chroma_invalid |-> !(|{o_chroma_x, o_chroma_y}), "xy not zero")
    `RTXC_ASSERT(a_inv_sum, o_valid |-> o_chroma_invalid == (out_sum <= 0), "bad invalid flag")
endmodule
